// ===== rtl/core/dam_pkg.sv =====
package dam_pkg;

	localparam int MEM_WORDS = 100;
	localparam int MEM_AW = 7;
	localparam int DEC_BASE = 100;
	localparam int INSTR_MAX = 4399;
	localparam int OPC_W = 6;
	localparam int INSTR_LOW_W = 13;
	localparam int DIV100_MUL = 5243;
	localparam int DIV100_SHIFT = 19;

	localparam logic [OPC_W-1:0] OP_READ = 6'd10;
	localparam logic [OPC_W-1:0] OP_WRITE = 6'd11;
	localparam logic [OPC_W-1:0] OP_LOAD = 6'd20;
	localparam logic [OPC_W-1:0] OP_STORE = 6'd21;
	localparam logic [OPC_W-1:0] OP_ADD = 6'd30;
	localparam logic [OPC_W-1:0] OP_SUB = 6'd31;
	localparam logic [OPC_W-1:0] OP_DIV = 6'd32;
	localparam logic [OPC_W-1:0] OP_MUL = 6'd33;
	localparam logic [OPC_W-1:0] OP_BR = 6'd40;
	localparam logic [OPC_W-1:0] OP_BRNEG = 6'd41;
	localparam logic [OPC_W-1:0] OP_BRZERO = 6'd42;
	localparam logic [OPC_W-1:0] OP_HALT = 6'd43;

	typedef enum logic [1:0] {
		FN_LOAD = 2'd0,
		FN_EXEC = 2'd1,
		FN_RESTART = 2'd2
	} func_t;

	typedef enum logic [2:0] {
		ST_LOADED = 3'd0,
		ST_RAN = 3'd1,
		ST_HALTED = 3'd2,
		ST_DIV_ZERO = 3'd3,
		ST_BAD_OP = 3'd4,
		ST_PC_OVF = 3'd5,
		ST_STOPPED = 3'd6
	} status_t;

	typedef enum logic [1:0] {
		MODE_RUN = 2'd0,
		MODE_HALT = 2'd1,
		MODE_FAULT = 2'd2
	} mode_t;

	typedef enum logic {
		MDU_MUL = 1'b0,
		MDU_DIV = 1'b1
	} mdu_op_t;

	typedef enum logic [2:0] {
		ACC_ZERO = 3'd0,
		ACC_MEM = 3'd1,
		ACC_ADD = 3'd2,
		ACC_SUB = 3'd3,
		ACC_MDU = 3'd4
	} acc_src_t;

	typedef enum logic {
		WR_DIN = 1'b0,
		WR_ACC = 1'b1
	} wr_src_t;

	typedef enum logic {
		ADDR_IN = 1'b0,
		ADDR_OPR = 1'b1
	} wr_addr_sel_t;

	typedef enum logic {
		RD_PC = 1'b0,
		RD_OPR = 1'b1
	} rd_sel_t;

	typedef struct packed {
		logic [1:0] func;
		logic [6:0] address;
		logic signed [31:0] data;
	} in_t;

	typedef struct packed {
		logic [2:0] status;
		logic write_valid;
		logic signed [31:0] write_value;
		logic [6:0] program_counter;
		logic signed [31:0] acc_value;
	} out_t;

	typedef struct packed {
		logic latch_in;
		logic clr_write;
		logic rd_en;
		rd_sel_t rd_sel;
		logic wr_en;
		wr_addr_sel_t wr_addr_sel;
		wr_src_t wr_src;
		logic dec_load;
		logic opr_load;
		logic acc_we;
		acc_src_t acc_src;
		logic pc_clr;
		logic pc_inc;
		logic pc_load;
		logic set_write;
		logic mdu_start;
		mdu_op_t mdu_op;
		logic out_load;
		status_t status;
	} cmd_t;

	typedef struct packed {
		logic [1:0] func;
		logic addr_ok;
		logic pc_end;
		logic bad;
		logic [OPC_W-1:0] opc;
		logic acc_neg;
		logic acc_zero;
		logic m_zero;
		logic mdu_done;
	} sts_t;

endpackage

// ===== rtl/core/decimal_accumulator_cpu.sv =====
// A decimal accumulator machine with a 100-word store, a 7-bit instruction counter and one
// WORD_BITS-wide accumulator, as wide as each store word. Each input transfer loads
// a store word, restarts the counter and accumulator, or executes one instruction, and each
// one yields exactly one output transfer with the status, any written word, the counter and
// the accumulator. The block takes one item at a time. A load, a restart, an unused function
// code, or an execute on a stopped machine or past the end of the store goes from dispatch
// straight to finish, where its result is registered. An instruction word that is negative
// or above the last opcode faults in the operand state. An ordinary instruction passes
// fetch, decode, operand read and execute in turn on the single store read port, and a
// multiply or divide then waits in the MDU state, since both run one bit per cycle through
// a shared shift-add and restoring-divide unit. The next item is taken the cycle after the
// result is registered, even while that result still waits on the output. The store reads
// as zero after reset through one valid flip-flop per word, so no clearing pass runs.
module decimal_accumulator_cpu #(
	parameter int WORD_BITS = 32
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input dam_pkg::in_t in_data,
	output logic out_valid,
	input logic out_ready,
	output dam_pkg::out_t out_data
);

	import dam_pkg::*;

	cmd_t cmd;
	sts_t sts;

	dam_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.sts(sts),
		.cmd(cmd)
	);

	dam_datapath #(
		.WORD_BITS(WORD_BITS)
	) u_datapath (
		.clk(clk),
		.arst_n(arst_n),
		.in_data(in_data),
		.cmd(cmd),
		.sts(sts),
		.out_data(out_data)
	);

endmodule

// ===== rtl/core/dam_ram.sv =====
module dam_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 100
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] wr_addr,
	input logic [WIDTH-1:0] wr_data,
	input logic rd_en,
	input logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== rtl/core/dam_mdu.sv =====
module dam_mdu #(
	parameter int WORD_BITS = 32
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input dam_pkg::mdu_op_t op,
	input logic [WORD_BITS-1:0] a,
	input logic [WORD_BITS-1:0] b,
	output logic done,
	output logic [WORD_BITS-1:0] result
);

	import dam_pkg::*;

	localparam int CNT_W = $clog2(WORD_BITS);

	logic busy_q;
	logic done_q;
	logic [CNT_W-1:0] cnt_q;
	mdu_op_t op_q;
	logic neg_q;
	logic [WORD_BITS-1:0] x_q;
	logic [WORD_BITS-1:0] y_q;
	logic [WORD_BITS-1:0] r_q;
	logic [WORD_BITS:0] rem_sh;
	logic [WORD_BITS:0] diff;
	logic ge;

	assign rem_sh = {r_q, x_q[WORD_BITS-1]};
	assign diff = rem_sh - {1'b0, y_q};
	assign ge = ~diff[WORD_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CNT_W'(WORD_BITS - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			op_q <= op;
			r_q <= '0;
			if (op == MDU_DIV) begin
				x_q <= a[WORD_BITS-1] ? -a : a;
				y_q <= b[WORD_BITS-1] ? -b : b;
				neg_q <= a[WORD_BITS-1] ^ b[WORD_BITS-1];
			end else begin
				x_q <= a;
				y_q <= b;
				neg_q <= 1'b0;
			end
		end else if (busy_q) begin
			if (op_q == MDU_DIV) begin
				r_q <= ge ? diff[WORD_BITS-1:0] : rem_sh[WORD_BITS-1:0];
				x_q <= {x_q[WORD_BITS-2:0], ge};
			end else begin
				r_q <= r_q + (y_q[0] ? x_q : '0);
				x_q <= {x_q[WORD_BITS-2:0], 1'b0};
				y_q <= {1'b0, y_q[WORD_BITS-1:1]};
			end
		end
	end

	assign done = done_q;
	assign result = (op_q == MDU_DIV) ? (neg_q ? -x_q : x_q) : r_q;

endmodule

// ===== rtl/core/dam_datapath.sv =====
module dam_datapath #(
	parameter int WORD_BITS = 32
) (
	input logic clk,
	input logic arst_n,
	input dam_pkg::in_t in_data,
	input dam_pkg::cmd_t cmd,
	output dam_pkg::sts_t sts,
	output dam_pkg::out_t out_data
);

	import dam_pkg::*;

	localparam logic [WORD_BITS-1:0] INSTR_MAX_W = WORD_BITS'(INSTR_MAX);
	localparam int PROD_W = 2 * INSTR_LOW_W;

	in_t in_q;
	logic [WORD_BITS-1:0] din;
	logic [WORD_BITS-1:0] acc_q;
	logic [MEM_AW-1:0] pc_q;
	logic [WORD_BITS-1:0] wv_q;
	logic wvalid_q;
	logic [MEM_WORDS-1:0] vld_q;
	logic rvalid_q;
	logic [WORD_BITS-1:0] rdata;
	logic [WORD_BITS-1:0] mem_word;
	logic [MEM_AW-1:0] rd_addr;
	logic [MEM_AW-1:0] wr_addr;
	logic [WORD_BITS-1:0] wr_data;
	logic bad_q;
	logic [OPC_W-1:0] opc_q;
	logic [INSTR_LOW_W-1:0] low_q;
	logic [PROD_W-1:0] prod;
	logic [MEM_AW-1:0] opr;
	logic [MEM_AW-1:0] opr_q;
	logic mdu_done;
	logic [WORD_BITS-1:0] mdu_result;
	out_t out_q;

	assign din = WORD_BITS'(in_q.data);
	assign mem_word = rvalid_q ? rdata : '0;
	assign rd_addr = (cmd.rd_sel == RD_OPR) ? opr : pc_q;
	assign wr_addr = (cmd.wr_addr_sel == ADDR_OPR) ? opr_q : in_q.address;
	assign wr_data = (cmd.wr_src == WR_ACC) ? acc_q : din;

	assign prod = PROD_W'(mem_word[INSTR_LOW_W-1:0]) * PROD_W'(DIV100_MUL);
	assign opr = MEM_AW'(low_q - INSTR_LOW_W'(opc_q) * INSTR_LOW_W'(DEC_BASE));

	dam_ram #(
		.WIDTH(WORD_BITS),
		.DEPTH(MEM_WORDS)
	) u_ram (
		.clk(clk),
		.we(cmd.wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en(cmd.rd_en),
		.rd_addr(rd_addr),
		.rd_data(rdata)
	);

	dam_mdu #(
		.WORD_BITS(WORD_BITS)
	) u_mdu (
		.clk(clk),
		.arst_n(arst_n),
		.start(cmd.mdu_start),
		.op(cmd.mdu_op),
		.a(acc_q),
		.b(mem_word),
		.done(mdu_done),
		.result(mdu_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			pc_q <= '0;
			acc_q <= '0;
			wvalid_q <= 1'b0;
		end else begin
			if (cmd.wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (cmd.pc_clr) begin
				pc_q <= '0;
			end else if (cmd.pc_load) begin
				pc_q <= opr_q;
			end else if (cmd.pc_inc) begin
				pc_q <= pc_q + 1'b1;
			end
			if (cmd.acc_we) begin
				case (cmd.acc_src)
					ACC_ZERO: acc_q <= '0;
					ACC_MEM: acc_q <= mem_word;
					ACC_ADD: acc_q <= acc_q + mem_word;
					ACC_SUB: acc_q <= acc_q - mem_word;
					ACC_MDU: acc_q <= mdu_result;
					default: acc_q <= acc_q;
				endcase
			end
			if (cmd.clr_write) begin
				wvalid_q <= 1'b0;
			end else if (cmd.set_write) begin
				wvalid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			in_q <= in_data;
		end
		if (cmd.rd_en) begin
			rvalid_q <= vld_q[rd_addr];
		end
		if (cmd.dec_load) begin
			bad_q <= mem_word[WORD_BITS-1] || (mem_word > INSTR_MAX_W);
			opc_q <= prod[DIV100_SHIFT +: OPC_W];
			low_q <= mem_word[INSTR_LOW_W-1:0];
		end
		if (cmd.opr_load) begin
			opr_q <= opr;
		end
		if (cmd.set_write) begin
			wv_q <= mem_word;
		end
		if (cmd.out_load) begin
			out_q.status <= cmd.status;
			out_q.write_valid <= wvalid_q;
			out_q.write_value <= wvalid_q ? 32'(signed'(wv_q)) : '0;
			out_q.program_counter <= pc_q;
			out_q.acc_value <= 32'(signed'(acc_q));
		end
	end

	assign sts.func = in_q.func;
	assign sts.addr_ok = in_q.address < MEM_AW'(MEM_WORDS);
	assign sts.pc_end = pc_q >= MEM_AW'(MEM_WORDS);
	assign sts.bad = bad_q;
	assign sts.opc = opc_q;
	assign sts.acc_neg = acc_q[WORD_BITS-1];
	assign sts.acc_zero = (acc_q == '0);
	assign sts.m_zero = (mem_word == '0);
	assign sts.mdu_done = mdu_done;

	assign out_data = out_q;

endmodule

// ===== rtl/core/dam_ctrl.sv =====
module dam_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input logic out_ready,
	input dam_pkg::sts_t sts,
	output dam_pkg::cmd_t cmd
);

	import dam_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_DISPATCH = 7'b0000010,
		S_DECODE = 7'b0000100,
		S_OPERAND = 7'b0001000,
		S_EXECUTE = 7'b0010000,
		S_MDU = 7'b0100000,
		S_FINISH = 7'b1000000
	} state_t;

	state_t state_q;
	state_t state_d;
	mode_t mode_q;
	mode_t mode_d;
	status_t status_q;
	status_t status_d;
	logic out_valid_q;
	logic out_free;

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		mode_d = mode_q;
		status_d = status_q;
		in_ready = 1'b0;
		cmd = '0;
		cmd.rd_sel = RD_PC;
		cmd.wr_addr_sel = ADDR_IN;
		cmd.wr_src = WR_DIN;
		cmd.acc_src = ACC_ZERO;
		cmd.mdu_op = MDU_MUL;
		cmd.status = status_q;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.latch_in = 1'b1;
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				cmd.clr_write = 1'b1;
				state_d = S_FINISH;
				unique case (sts.func)
					FN_LOAD: begin
						cmd.wr_en = sts.addr_ok;
						status_d = ST_LOADED;
					end
					FN_RESTART: begin
						cmd.pc_clr = 1'b1;
						cmd.acc_we = 1'b1;
						mode_d = MODE_RUN;
						status_d = ST_LOADED;
					end
					FN_EXEC: begin
						if (mode_q != MODE_RUN) begin
							status_d = ST_STOPPED;
						end else if (sts.pc_end) begin
							mode_d = MODE_FAULT;
							status_d = ST_PC_OVF;
						end else begin
							cmd.rd_en = 1'b1;
							cmd.pc_inc = 1'b1;
							state_d = S_DECODE;
						end
					end
					default: begin
						status_d = ST_STOPPED;
					end
				endcase
			end
			S_DECODE: begin
				cmd.dec_load = 1'b1;
				state_d = S_OPERAND;
			end
			S_OPERAND: begin
				if (sts.bad) begin
					mode_d = MODE_FAULT;
					status_d = ST_BAD_OP;
					state_d = S_FINISH;
				end else begin
					cmd.rd_en = 1'b1;
					cmd.rd_sel = RD_OPR;
					cmd.opr_load = 1'b1;
					state_d = S_EXECUTE;
				end
			end
			S_EXECUTE: begin
				status_d = ST_RAN;
				state_d = S_FINISH;
				cmd.wr_addr_sel = ADDR_OPR;
				unique case (sts.opc)
					OP_READ: begin
						cmd.wr_en = 1'b1;
					end
					OP_WRITE: begin
						cmd.set_write = 1'b1;
					end
					OP_LOAD: begin
						cmd.acc_we = 1'b1;
						cmd.acc_src = ACC_MEM;
					end
					OP_STORE: begin
						cmd.wr_en = 1'b1;
						cmd.wr_src = WR_ACC;
					end
					OP_ADD: begin
						cmd.acc_we = 1'b1;
						cmd.acc_src = ACC_ADD;
					end
					OP_SUB: begin
						cmd.acc_we = 1'b1;
						cmd.acc_src = ACC_SUB;
					end
					OP_DIV: begin
						if (sts.m_zero) begin
							mode_d = MODE_FAULT;
							status_d = ST_DIV_ZERO;
						end else begin
							cmd.mdu_start = 1'b1;
							cmd.mdu_op = MDU_DIV;
							state_d = S_MDU;
						end
					end
					OP_MUL: begin
						cmd.mdu_start = 1'b1;
						state_d = S_MDU;
					end
					OP_BR: begin
						cmd.pc_load = 1'b1;
					end
					OP_BRNEG: begin
						cmd.pc_load = sts.acc_neg;
					end
					OP_BRZERO: begin
						cmd.pc_load = sts.acc_zero;
					end
					OP_HALT: begin
						mode_d = MODE_HALT;
						status_d = ST_HALTED;
					end
					default: begin
						mode_d = MODE_FAULT;
						status_d = ST_BAD_OP;
					end
				endcase
			end
			S_MDU: begin
				if (sts.mdu_done) begin
					cmd.acc_we = 1'b1;
					cmd.acc_src = ACC_MDU;
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			mode_q <= MODE_RUN;
			status_q <= ST_LOADED;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			mode_q <= mode_d;
			status_q <= status_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== rtl/core/dam_checker.sv =====
module dam_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input dam_pkg::out_t out_data
);

	import dam_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("Output changed or dropped while stalled.");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("Second input taken while an item is in work.");

	a_write_only_on_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.write_valid |-> out_data.status == ST_RAN)
		else $error("Written word reported with a status other than ran.");

	a_write_value_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.write_valid |-> out_data.write_value == '0)
		else $error("Write value not zero without a write.");

	a_pc_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.program_counter <= 7'(MEM_WORDS))
		else $error("Instruction counter beyond its range.");

endmodule

bind decimal_accumulator_cpu dam_checker u_dam_checker (.*);
